FILE: rtl/core/sobel_et_pkg.sv
// Shared types and constants for the Sobel edge threshold block.
// Used by the channel interfaces, the gray converter and the top level.
// No dependencies.
package sobel_et_pkg;

  // Configuration port geometry.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH    = 2'd0,
    REG_FRAME_HEIGHT   = 2'd1,
    REG_EDGE_THRESHOLD = 2'd2
  } cfg_reg_t;

  // Field widths of the configuration registers.
  localparam int FW_W  = 12;
  localparam int FH_W  = 16;
  localparam int THR_W = 11;

  // Register reset values.
  localparam logic [FW_W-1:0]  FRAME_WIDTH_RST    = 12'd640;
  localparam logic [FH_W-1:0]  FRAME_HEIGHT_RST   = 16'd480;
  localparam logic [THR_W-1:0] EDGE_THRESHOLD_RST = 11'd125;

  // Smallest frame dimension.
  localparam int FRAME_DIM_MIN = 3;

  // Squared limit: (threshold + 1)^2 needs up to 23 bits.
  localparam int LIM_W = 23;
  localparam logic [LIM_W-1:0] LIM_RST = 23'd15876;

  // Gray conversion: (300 R + 590 G + 110 B) / 1000, truncated.
  // The divide is a multiply by ceil(2^28 / 1000), exact for sums below 493k.
  localparam int WSUM_W = 18;
  localparam logic [WSUM_W-1:0] GRAY_WR = 18'd300;
  localparam logic [WSUM_W-1:0] GRAY_WG = 18'd590;
  localparam logic [WSUM_W-1:0] GRAY_WB = 18'd110;
  localparam int RECIP_W    = 19;
  localparam int PROD_W     = WSUM_W + RECIP_W;
  localparam logic [RECIP_W-1:0] GRAY_RECIP = 19'd268436;
  localparam int GRAY_SHIFT = 28;

  // Sobel gradient width (signed, magnitude up to 1020).
  localparam int GRAD_W = 11;

  // Control flags that travel with an item past the counter stage.
  typedef struct packed {
    logic pix;     // item is a pixel, not a flush tick
    logic emit;    // item releases one result
    logic border;  // released position lies on the frame border
    logic last;    // released position is the last of the frame
  } item_ctl_t;

endpackage

FILE: rtl/core/sobel_et_if.sv
// Valid/ready channel interfaces for pixels, results and configuration writes.
// Depends on sobel_et_pkg for field widths.

// Pixel input channel.
interface sobel_et_pix_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] blue;
  logic [7:0] green;
  logic [7:0] red;

  modport source (output valid, mode, blue, green, red, input ready);
  modport sink   (input valid, mode, blue, green, red, output ready);
endinterface

// Edge result channel.
interface sobel_et_res_if;
  logic valid;
  logic ready;
  logic edge_res;
  logic last_of_frame;

  modport source (output valid, edge_res, last_of_frame, input ready);
  modport sink   (input valid, edge_res, last_of_frame, output ready);
endinterface

// Configuration write channel.
interface sobel_et_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [sobel_et_pkg::CFG_IDX_W-1:0]  index;
  logic [sobel_et_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/core/sobel_et_ram.sv
// Generic simple dual-port RAM: one write port, one read port with a
// registered read that holds while the read enable is low. No dependencies.
module sobel_et_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/core/sobel_et_gray.sv
// Two-stage BGR to gray converter: weighted sum, then the divide by 1000
// done as a reciprocal multiply. Depends on sobel_et_pkg.
module sobel_et_gray (
  input  logic       clk,
  input  logic       en_sum,
  input  logic       en_div,
  input  logic [7:0] blue,
  input  logic [7:0] green,
  input  logic [7:0] red,
  output logic [7:0] gray
);
  import sobel_et_pkg::*;

  logic [WSUM_W-1:0] wsum_r;
  logic [WSUM_W-1:0] wsum_nxt;
  logic [PROD_W-1:0] prod;
  logic [7:0]        gray_r;

  // Weighted channel sum; the constant products reduce to shifts and adds.
  assign wsum_nxt = GRAY_WR * WSUM_W'(red) + GRAY_WG * WSUM_W'(green)
                  + GRAY_WB * WSUM_W'(blue);

  always_ff @(posedge clk) begin
    if (en_sum) begin
      wsum_r <= wsum_nxt;
    end
  end

  // Truncating divide by 1000.
  assign prod = PROD_W'(wsum_r) * PROD_W'(GRAY_RECIP);

  always_ff @(posedge clk) begin
    if (en_div) begin
      gray_r <= prod[GRAY_SHIFT+7:GRAY_SHIFT];
    end
  end

  assign gray = gray_r;

endmodule

FILE: rtl/core/sobel_edge_threshold.sv
// Sobel 3x3 edge detector with a magnitude threshold on a BGR pixel stream.
// Throughput: one item per cycle unless the output stalls; a result taken
// from the output register frees the pipeline in the same cycle. An item
// moves through the gray, counter, window and magnitude stages to the output.
// Reset (synchronous, active low) restores the register defaults and clears
// the position counters; line stores need no clear since every interior
// window is filled from the current frame before it is used.
module sobel_edge_threshold #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                  clk,
  input  logic                  rst_n,
  sobel_et_pix_if.sink          in_pix,
  sobel_et_res_if.source        out_res,
  sobel_et_cfg_if.sink          cfg_wr
);
  import sobel_et_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);      // column index
  localparam int WW = $clog2(MAX_WIDTH + 1);  // frame width value
  localparam int PW = $clog2(MAX_WIDTH + 3);  // pending distance, up to width + 2

  // ---------------------------------------------------------------
  // Configuration registers.
  logic [WW-1:0]    width_r, width_nxt;
  logic [FH_W-1:0]  height_r, height_nxt;
  logic [LIM_W-1:0] lim_r, lim_nxt;
  logic [FW_W-1:0]  cfg_w;
  logic [FH_W-1:0]  cfg_h;
  logic [FW_W-1:0]  thr_p1;
  logic [2*FW_W-1:0] thr_sq;
  logic             cfg_go;
  logic             pos_clear;

  assign cfg_wr.ready = 1'b1;
  assign cfg_go       = cfg_wr.valid;
  assign cfg_w        = cfg_wr.data[FW_W-1:0];
  assign cfg_h        = cfg_wr.data[FH_W-1:0];
  assign thr_p1       = FW_W'(cfg_wr.data[THR_W-1:0]) + FW_W'(1);
  assign thr_sq       = thr_p1 * thr_p1;

  // Clamp the written sizes and precompute the squared limit.
  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    lim_nxt    = lim_r;
    pos_clear  = 1'b0;
    if (cfg_go) begin
      case (cfg_wr.index)
        REG_FRAME_WIDTH: begin
          pos_clear = 1'b1;
          if (cfg_w < FW_W'(FRAME_DIM_MIN)) begin
            width_nxt = WW'(FRAME_DIM_MIN);
          end else if (32'(cfg_w) > MAX_WIDTH) begin
            width_nxt = WW'(MAX_WIDTH);
          end else begin
            width_nxt = WW'(cfg_w);
          end
        end
        REG_FRAME_HEIGHT: begin
          pos_clear = 1'b1;
          if (cfg_h < FH_W'(FRAME_DIM_MIN)) begin
            height_nxt = FH_W'(FRAME_DIM_MIN);
          end else begin
            height_nxt = cfg_h;
          end
        end
        REG_EDGE_THRESHOLD: begin
          lim_nxt = LIM_W'(thr_sq);
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WW'(FRAME_WIDTH_RST);
      height_r <= FRAME_HEIGHT_RST;
      lim_r    <= LIM_RST;
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
      lim_r    <= lim_nxt;
    end
  end

  // ---------------------------------------------------------------
  // Pipeline handshake: each stage moves when the next one is free.
  logic s1_v_r, s2_v_r, s3_v_r, s4_v_r, out_v_r;
  logic s1_mode_r, s2_mode_r;
  logic o_free, rdy4, rdy3, rdy2, rdy1;
  logic in_go, s1_go, s2_go, s3_go, s4_go;
  item_ctl_t s3_ctl_r, s4_ctl_r;

  assign o_free = !out_v_r || out_res.ready;
  assign rdy4   = !s4_v_r || o_free;
  assign s4_go  = s4_v_r && o_free;
  assign s3_go  = s3_v_r && (rdy4 || !s3_ctl_r.emit);
  assign rdy3   = !s3_v_r || s3_go;
  assign s2_go  = s2_v_r && rdy3;
  assign rdy2   = !s2_v_r || s2_go;
  assign s1_go  = s1_v_r && rdy2;
  assign rdy1   = !s1_v_r || s1_go;
  assign in_go  = in_pix.valid && rdy1;

  assign in_pix.ready = rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      s4_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_go) begin
        s1_v_r <= 1'b1;
      end else if (s1_go) begin
        s1_v_r <= 1'b0;
      end
      if (s1_go) begin
        s2_v_r <= 1'b1;
      end else if (s2_go) begin
        s2_v_r <= 1'b0;
      end
      if (s2_go) begin
        s3_v_r <= 1'b1;
      end else if (s3_go) begin
        s3_v_r <= 1'b0;
      end
      if (s3_go && s3_ctl_r.emit) begin
        s4_v_r <= 1'b1;
      end else if (s4_go) begin
        s4_v_r <= 1'b0;
      end
      if (s4_go) begin
        out_v_r <= 1'b1;
      end else if (out_res.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  // Mode travels alongside the gray converter stages.
  always_ff @(posedge clk) begin
    if (in_go) begin
      s1_mode_r <= in_pix.mode;
    end
    if (s1_go) begin
      s2_mode_r <= s1_mode_r;
    end
  end

  // ---------------------------------------------------------------
  // Stages 1 and 2: gray conversion.
  logic [7:0] gray;

  sobel_et_gray u_gray (
    .clk    (clk),
    .en_sum (in_go),
    .en_div (s1_go),
    .blue   (in_pix.blue),
    .green  (in_pix.green),
    .red    (in_pix.red),
    .gray   (gray)
  );

  // ---------------------------------------------------------------
  // Stage 2 to 3: position counters and the release decision.
  logic [CW-1:0]   in_col_r, in_col_nxt;
  logic [CW-1:0]   out_col_r, out_col_nxt;
  logic [FH_W-1:0] out_row_r, out_row_nxt;
  logic [PW-1:0]   pend_r, pend_nxt;
  logic [PW-1:0]   pend_p1;
  logic            s2_pix;
  logic            in_col_last;
  logic            out_col_last;
  logic            out_row_last;
  logic            out_border;
  item_ctl_t       ctl_nxt;

  assign s2_pix       = !s2_mode_r;
  assign pend_p1      = pend_r + PW'(1);
  assign in_col_last  = (WW'(in_col_r) >= width_r - WW'(1));
  assign out_col_last = (WW'(out_col_r) >= width_r - WW'(1));
  assign out_row_last = (out_row_r >= height_r - FH_W'(1));
  assign out_border   = (out_row_r == '0) || (out_col_r == '0) ||
                        out_row_last || out_col_last;

  always_comb begin
    in_col_nxt  = in_col_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    pend_nxt    = pend_r;
    ctl_nxt.pix    = s2_pix;
    ctl_nxt.border = out_border;
    ctl_nxt.last   = out_row_last && out_col_last;
    if (s2_pix) begin
      ctl_nxt.emit = (pend_p1 >= PW'(width_r) + PW'(2));
    end else begin
      ctl_nxt.emit = (pend_r != '0) && out_border;
    end
    if (s2_go) begin
      // Input position moves on every pixel.
      if (s2_pix) begin
        in_col_nxt = in_col_last ? '0 : in_col_r + CW'(1);
      end
      // Output position moves on every released result.
      if (ctl_nxt.emit) begin
        if (out_col_last) begin
          out_col_nxt = '0;
          out_row_nxt = out_row_last ? '0 : out_row_r + FH_W'(1);
        end else begin
          out_col_nxt = out_col_r + CW'(1);
        end
      end
      pend_nxt = (s2_pix ? pend_p1 : pend_r) - PW'(ctl_nxt.emit);
    end
    if (pos_clear) begin
      in_col_nxt  = '0;
      out_col_nxt = '0;
      out_row_nxt = '0;
      pend_nxt    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_col_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
      pend_r    <= '0;
    end else begin
      in_col_r  <= in_col_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
      pend_r    <= pend_nxt;
    end
  end

  // Stage 3 payload.
  logic [7:0]    s3_gray_r;
  logic [CW-1:0] s3_col_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_ctl_r <= '0;
    end else if (s2_go) begin
      s3_ctl_r <= ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_go) begin
      s3_gray_r <= gray;
      s3_col_r  <= in_col_r;
    end
  end

  // ---------------------------------------------------------------
  // Line stores: read as the pixel enters stage 3, written as it leaves.
  logic [7:0] top;
  logic [7:0] mid;
  logic       line_re;
  logic       line_we;

  assign line_re = s2_go && s2_pix;
  assign line_we = s3_go && s3_ctl_r.pix;

  sobel_et_ram #(
    .WIDTH (8),
    .DEPTH (MAX_WIDTH)
  ) u_upper (
    .clk   (clk),
    .we    (line_we),
    .waddr (s3_col_r),
    .wdata (mid),
    .re    (line_re),
    .raddr (in_col_r),
    .rdata (top)
  );

  sobel_et_ram #(
    .WIDTH (8),
    .DEPTH (MAX_WIDTH)
  ) u_middle (
    .clk   (clk),
    .we    (line_we),
    .waddr (s3_col_r),
    .wdata (s3_gray_r),
    .re    (line_re),
    .raddr (in_col_r),
    .rdata (mid)
  );

  // ---------------------------------------------------------------
  // Stage 3 to 4: window shift and Sobel gradients of the shifted window.
  logic [7:0] win_r [9];
  logic signed [GRAD_W-1:0] wa, wb, wc, wd, wf, wg, wh, wi;
  logic signed [GRAD_W-1:0] gx_nxt, gy_nxt;
  logic signed [GRAD_W-1:0] s4_gx_r, s4_gy_r;

  always_ff @(posedge clk) begin
    if (line_we) begin
      win_r[0] <= win_r[1];
      win_r[1] <= win_r[2];
      win_r[2] <= top;
      win_r[3] <= win_r[4];
      win_r[4] <= win_r[5];
      win_r[5] <= mid;
      win_r[6] <= win_r[7];
      win_r[7] <= win_r[8];
      win_r[8] <= s3_gray_r;
    end
  end

  // Corners and edges of the window as it stands after this pixel's shift.
  assign wa = $signed({3'b000, win_r[1]});
  assign wb = $signed({3'b000, win_r[2]});
  assign wc = $signed({3'b000, top});
  assign wd = $signed({3'b000, win_r[4]});
  assign wf = $signed({3'b000, mid});
  assign wg = $signed({3'b000, win_r[7]});
  assign wh = $signed({3'b000, win_r[8]});
  assign wi = $signed({3'b000, s3_gray_r});

  assign gx_nxt = (wc - wa) + (wf - wd) + (wf - wd) + (wi - wg);
  assign gy_nxt = (wg - wa) + (wh - wb) + (wh - wb) + (wi - wc);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_ctl_r <= '0;
    end else if (s3_go && s3_ctl_r.emit) begin
      s4_ctl_r <= s3_ctl_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_go && s3_ctl_r.emit) begin
      s4_gx_r <= gx_nxt;
      s4_gy_r <= gy_nxt;
    end
  end

  // ---------------------------------------------------------------
  // Stage 4 to output: squared magnitude against the squared limit; border positions give no edge.
  logic signed [2*GRAD_W-1:0] sqx, sqy;
  logic [LIM_W-1:0]           mag2;
  logic                       edge_nxt;
  logic                       edge_r;
  logic                       last_r;

  assign sqx      = s4_gx_r * s4_gx_r;
  assign sqy      = s4_gy_r * s4_gy_r;
  assign mag2     = LIM_W'($unsigned(sqx)) + LIM_W'($unsigned(sqy));
  assign edge_nxt = !s4_ctl_r.border && (mag2 >= lim_r);

  always_ff @(posedge clk) begin
    if (s4_go) begin
      edge_r <= edge_nxt;
      last_r <= s4_ctl_r.last;
    end
  end

  assign out_res.valid         = out_v_r;
  assign out_res.edge_res      = edge_r;
  assign out_res.last_of_frame = last_r;

endmodule
